[design/bpl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_pkg: shared types and constants for the BSP point locator
// Item and result layouts, node entry layout, walk state encoding.
// ----------------------------------------------------------------------------
package bpl_pkg;

	localparam int COORD_W   = 32;
	localparam int LINK_W    = 16;
	localparam int SUBSEC_W  = 15;
	localparam int COUNT_W   = 12;
	localparam int NODE_ID_W = 11;
	localparam int FRAC_BITS = 16;
	localparam int LEAF_BIT  = 15;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	localparam logic SIDE_FRONT = 1'b0;
	localparam logic SIDE_BACK  = 1'b1;

	typedef struct packed {
		logic                        command;
		logic [NODE_ID_W-1:0]        node_index;
		logic signed [COORD_W-1:0]   line_x;
		logic signed [COORD_W-1:0]   line_y;
		logic signed [COORD_W-1:0]   line_dx;
		logic signed [COORD_W-1:0]   line_dy;
		logic [LINK_W-1:0]           front_child;
		logic [LINK_W-1:0]           back_child;
		logic signed [COORD_W-1:0]   point_x;
		logic signed [COORD_W-1:0]   point_y;
	} bpl_item_t;

	typedef struct packed {
		logic [SUBSEC_W-1:0] subsector_index;
		logic                walk_error;
	} bpl_result_t;

	// One node table entry as it sits in the memory.
	typedef struct packed {
		logic [COORD_W-1:0] line_x;
		logic [COORD_W-1:0] line_y;
		logic [COORD_W-1:0] line_dx;
		logic [COORD_W-1:0] line_dy;
		logic [LINK_W-1:0]  back_child;
		logic [LINK_W-1:0]  front_child;
	} bpl_node_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRAP,
		ST_EVAL,
		ST_STEP
	} bpl_state_t;

endpackage

[design/bpl_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_ram: generic single-port synchronous RAM
// One access per cycle, write or read; read data is registered.
// ----------------------------------------------------------------------------
module bpl_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic             re,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [0:DEPTH-1];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

[design/bpl_index_wrap.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bpl_index_wrap: reduces a node link to a table address
// Power-of-two tables mask the link into a register; other sizes register the
// link, a reciprocal-multiply quotient and then a multiply-subtract remainder.
// ----------------------------------------------------------------------------
module bpl_index_wrap
	import bpl_pkg::*;
#(
	parameter int NODE_ENTRIES = 2048,
	localparam int AW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [LINK_W-1:0] value,
	output logic              done,
	output logic [AW-1:0]     idx
);

	localparam bit IS_POW2 = ((NODE_ENTRIES & (NODE_ENTRIES - 1)) == 0);

	generate
		if (IS_POW2) begin : g_mask
			localparam logic [AW-1:0] MASK = AW'(NODE_ENTRIES - 1);
			logic          done_q;
			logic [AW-1:0] idx_q;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					done_q <= 1'b0;
				end else begin
					done_q <= start;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					idx_q <= value[AW-1:0] & MASK;
				end
			end

			assign done = done_q;
			assign idx  = idx_q;
		end else begin : g_recip
			// The rounded-up reciprocal with a shift of LINK_W plus the divisor
			// width gives the exact quotient for every LINK_W-bit value.
			localparam int DIV_L   = $clog2(NODE_ENTRIES);
			localparam int DIV_S   = LINK_W + DIV_L;
			localparam int RECIP_W = LINK_W + 2;
			localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(
				((64'd1 << DIV_S) + 64'(NODE_ENTRIES) - 64'd1) / 64'(NODE_ENTRIES));
			localparam logic [LINK_W-1:0] DIVISOR = LINK_W'(NODE_ENTRIES);
			logic                      valid_s1, valid_s2, done_q;
			logic [LINK_W-1:0]         value_s1, value_s2, quot_s2;
			logic [AW-1:0]             idx_q;
			logic [LINK_W+RECIP_W-1:0] product;
			logic [LINK_W-1:0]         quotient;
			logic [LINK_W-1:0]         remainder;

			assign product   = value_s1 * RECIP;
			assign quotient  = LINK_W'(product >> DIV_S);
			assign remainder = value_s2 - quot_s2 * DIVISOR;

			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					valid_s1 <= 1'b0;
					valid_s2 <= 1'b0;
					done_q   <= 1'b0;
				end else begin
					valid_s1 <= start;
					valid_s2 <= valid_s1;
					done_q   <= valid_s2;
				end
			end

			always_ff @(posedge clk) begin
				if (start) begin
					value_s1 <= value;
				end
				if (valid_s1) begin
					value_s2 <= value_s1;
					quot_s2  <= quotient;
				end
				if (valid_s2) begin
					idx_q <= remainder[AW-1:0];
				end
			end

			assign done = done_q;
			assign idx  = idx_q;
		end
	endgenerate

endmodule

[design/bsp_point_locate.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_point_locate: point location in a binary space partition tree
// Loads partition nodes into a node table and walks it for query points.
// ----------------------------------------------------------------------------
// A load item writes one node entry and gives no result; it keeps busy high
// until the entry is written. A query walks from the root node, one node per
// round (address reduction, node table read, side selection); the result is
// registered and shown in the cycle after the last round, and an empty tree
// answers in the cycle after its query is taken. When NODE_ENTRIES is not a
// power of two every address reduction, for a load as well as for each round,
// uses the reciprocal division of bpl_index_wrap. The result is presented for
// exactly one cycle with done high, and the receiver cannot stall it. A new
// item may start in the cycle in which a result is shown. The user must write
// node_count through the cfg channel only while idle; the block never checks.
// ----------------------------------------------------------------------------
module bsp_point_locate
	import bpl_pkg::*;
#(
	parameter int NODE_ENTRIES = 2048
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  bpl_item_t          item,
	output logic               done,
	output bpl_result_t        result,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [COUNT_W-1:0] cfg_data
);

	localparam int AW = (NODE_ENTRIES > 1) ? $clog2(NODE_ENTRIES) : 1;

	bpl_state_t         state_q, state_d;
	logic [COUNT_W-1:0] node_count_q;
	logic [COUNT_W-1:0] steps_q, steps_d;
	bpl_item_t          item_q;
	logic               done_q, done_d;
	bpl_result_t        result_q, result_d;

	logic               accept;
	logic               wrap_start;
	logic [LINK_W-1:0]  wrap_value;
	logic               wrap_done;
	logic [AW-1:0]      wrap_idx;

	logic               ram_we, ram_re;
	bpl_node_t          ram_wdata, node_rd;

	// Side selection terms, captured in the evaluation cycle.
	logic               spec_q;
	logic               spec_side_q;
	logic signed [31:0] left_q, right_q;
	logic [LINK_W-1:0]  front_q, back_q;

	logic               spec, spec_side;
	logic [31:0]        diff_x, diff_y;
	logic signed [31:0] prod_left, prod_right;
	logic               side;
	logic [LINK_W-1:0]  link_next;
	logic [COUNT_W-1:0] steps_next;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign cfg_ready = 1'b1;
	assign done      = done_q;
	assign result    = result_q;

	bpl_index_wrap #(
		.NODE_ENTRIES(NODE_ENTRIES)
	) u_wrap (
		.clk   (clk),
		.arst_n(arst_n),
		.start (wrap_start),
		.value (wrap_value),
		.done  (wrap_done),
		.idx   (wrap_idx)
	);

	assign ram_wdata = '{
		line_x:      item_q.line_x,
		line_y:      item_q.line_y,
		line_dx:     item_q.line_dx,
		line_dy:     item_q.line_dy,
		back_child:  item_q.back_child,
		front_child: item_q.front_child
	};

	bpl_ram #(
		.WIDTH($bits(bpl_node_t)),
		.DEPTH(NODE_ENTRIES)
	) u_nodes (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (wrap_idx),
		.wdata(ram_wdata),
		.rdata(node_rd)
	);

	// Axis-aligned lines compare the full coordinate; others use the sign of
	// a cross product of the integer parts.
	always_comb begin
		spec      = 1'b0;
		spec_side = SIDE_FRONT;
		if (node_rd.line_dx == '0) begin
			spec = 1'b1;
			if ($signed(item_q.point_x) <= $signed(node_rd.line_x)) begin
				spec_side = ($signed(node_rd.line_dy) > 0);
			end else begin
				spec_side = ($signed(node_rd.line_dy) < 0);
			end
		end else if (node_rd.line_dy == '0) begin
			spec = 1'b1;
			if ($signed(item_q.point_y) <= $signed(node_rd.line_y)) begin
				spec_side = ($signed(node_rd.line_dx) < 0);
			end else begin
				spec_side = ($signed(node_rd.line_dx) > 0);
			end
		end
	end

	assign diff_x     = item_q.point_x - node_rd.line_x;
	assign diff_y     = item_q.point_y - node_rd.line_y;
	assign prod_left  = $signed(node_rd.line_dy[31:FRAC_BITS]) * $signed(diff_x[31:FRAC_BITS]);
	assign prod_right = $signed(diff_y[31:FRAC_BITS]) * $signed(node_rd.line_dx[31:FRAC_BITS]);

	assign side       = spec_q ? spec_side_q : ((right_q < left_q) ? SIDE_FRONT : SIDE_BACK);
	assign link_next  = (side == SIDE_BACK) ? back_q : front_q;
	assign steps_next = steps_q + 1'b1;

	always_comb begin
		state_d    = state_q;
		steps_d    = steps_q;
		done_d     = 1'b0;
		result_d   = result_q;
		wrap_start = 1'b0;
		wrap_value = '0;
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (item.command == CMD_LOAD) begin
						wrap_start = 1'b1;
						wrap_value = LINK_W'(item.node_index);
						state_d    = ST_WRAP;
					end else if (node_count_q == '0) begin
						done_d   = 1'b1;
						result_d = '{subsector_index: '0, walk_error: 1'b0};
					end else begin
						wrap_start = 1'b1;
						wrap_value = LINK_W'(node_count_q - 1'b1);
						steps_d    = '0;
						state_d    = ST_WRAP;
					end
				end
			end
			ST_WRAP: begin
				if (wrap_done) begin
					if (item_q.command == CMD_LOAD) begin
						ram_we  = 1'b1;
						state_d = ST_IDLE;
					end else begin
						ram_re  = 1'b1;
						state_d = ST_EVAL;
					end
				end
			end
			ST_EVAL: begin
				state_d = ST_STEP;
			end
			ST_STEP: begin
				steps_d = steps_next;
				if (link_next[LEAF_BIT]) begin
					done_d   = 1'b1;
					result_d = '{subsector_index: link_next[SUBSEC_W-1:0], walk_error: 1'b0};
					state_d  = ST_IDLE;
				end else if (steps_next >= node_count_q) begin
					done_d   = 1'b1;
					result_d = '{subsector_index: '0, walk_error: 1'b1};
					state_d  = ST_IDLE;
				end else begin
					wrap_start = 1'b1;
					wrap_value = link_next;
					state_d    = ST_WRAP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			node_count_q <= '0;
			steps_q      <= '0;
			done_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			steps_q <= steps_d;
			done_q  <= done_d;
			if (cfg_valid && cfg_ready) begin
				node_count_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk) begin
		result_q <= result_d;
		if (accept) begin
			item_q <= item;
		end
		if (state_q == ST_EVAL) begin
			spec_q      <= spec;
			spec_side_q <= spec_side;
			left_q      <= prod_left;
			right_q     <= prod_right;
			front_q     <= node_rd.front_child;
			back_q      <= node_rd.back_child;
		end
	end

endmodule
